// ===== rtl/hwm_pkg.sv =====
package hwm_pkg;

    localparam int FRAC_BITS   = 32;
    localparam int STATE_W     = 48;
    localparam int SUM_W       = STATE_W + 4;
    localparam int COEF_W      = 32;
    localparam int CUR_W       = 16;
    localparam int ANGLE_W     = 32;
    localparam int MUL_LO_W    = 32;
    localparam int MUL_W       = MUL_LO_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = STATE_W + COEF_W + 2;
    localparam int COEF_SHIFT  = 32;
    localparam int HEAT_SHIFT  = 24;
    localparam int ANGLE_FRAC  = 24;
    localparam int OUT_SHR     = (FRAC_BITS >= ANGLE_FRAC) ? FRAC_BITS - ANGLE_FRAC : 0;
    localparam int OUT_SHL     = (FRAC_BITS < ANGLE_FRAC) ? ANGLE_FRAC - FRAC_BITS : 0;
    localparam int OUT_WIDE_W  = STATE_W + 8;
    localparam int REG_IDX_W   = 3;
    localparam int NUM_STEPS   = 23;
    localparam int STEP_W      = 5;

    localparam logic [REG_IDX_W-1:0] REG_HEAT_GAIN   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TEMPCO      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COOL_COEF   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TORQUE_COEF = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DAMP_COEF   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SPRING_COEF = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TIME_STEP   = 3'd6;

    localparam logic [COEF_W-1:0] RST_HEAT_GAIN   = 32'd26843546;
    localparam logic [COEF_W-1:0] RST_TEMPCO      = 32'd16879221;
    localparam logic [COEF_W-1:0] RST_COOL_COEF   = 32'd298262;
    localparam logic [COEF_W-1:0] RST_TORQUE_COEF = 32'd111848;
    localparam logic [COEF_W-1:0] RST_DAMP_COEF   = 32'd447392;
    localparam logic [COEF_W-1:0] RST_SPRING_COEF = 32'd22369621;
    localparam logic [COEF_W-1:0] RST_TIME_STEP   = 32'd89478;

    localparam logic signed [ACC_W-1:0] ACC_SMAX =
        {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_SMIN = ~ACC_SMAX;
    localparam logic signed [SUM_W-1:0] SUM_ONE  = SUM_W'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic [COEF_W-1:0] heat_gain;
        logic [COEF_W-1:0] tempco;
        logic [COEF_W-1:0] cool_coef;
        logic [COEF_W-1:0] torque_coef;
        logic [COEF_W-1:0] damp_coef;
        logic [COEF_W-1:0] spring_coef;
        logic [COEF_W-1:0] time_step;
    } coef_t;

    typedef enum logic [2:0] {OA_CUR, OA_I2, OA_U, OA_W, OA_A, OA_F} opa_t;
    typedef enum logic {HALF_LO, HALF_HI} half_t;
    typedef enum logic [3:0] {
        OB_CUR, OB_HEAT_GAIN, OB_TEMPCO, OB_COOL, OB_TORQUE,
        OB_DAMP, OB_SPRING, OB_TSTEP, OB_G
    } opb_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD_HI} acc_op_t;
    typedef enum logic [2:0] {
        SUM_HOLD, SUM_BASE_ADD, SUM_BASE_SUB, SUM_ADD, SUM_SUB
    } sum_op_t;
    typedef enum logic [1:0] {BASE_ONE, BASE_U, BASE_W, BASE_A} base_t;
    typedef enum logic {SH_32, SH_24} shift_t;
    typedef enum logic [2:0] {DST_NONE, DST_G, DST_F, DST_U, DST_W, DST_A} dst_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_WAIT_OUT, SEQ_DONE} seq_t;

    typedef struct packed {
        opa_t    opa;
        half_t   half;
        opb_t    opb;
        acc_op_t acc_op;
        sum_op_t sum_op;
        base_t   base;
        shift_t  shift;
        dst_t    dst;
        seq_t    seq;
    } ctl_t;

    localparam ctl_t CTL_NOP = '{
        opa: OA_CUR, half: HALF_LO, opb: OB_CUR, acc_op: ACC_HOLD,
        sum_op: SUM_HOLD, base: BASE_ONE, shift: SH_32, dst: DST_NONE,
        seq: SEQ_NEXT
    };

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > ACC_SMAX)
            r = ACC_SMAX;
        else if (v < ACC_SMIN)
            r = ACC_SMIN;
        else
            r = v;
        return r[STATE_W-1:0];
    endfunction

    function automatic logic [ANGLE_W-1:0] to_angle(input logic signed [STATE_W-1:0] a);
        logic [OUT_WIDE_W-1:0] wide;
        wide = (OUT_WIDE_W'($unsigned(a)) >> OUT_SHR) << OUT_SHL;
        if (|wide[OUT_WIDE_W-1:ANGLE_W])
            return '1;
        return wide[ANGLE_W-1:0];
    endfunction

    function automatic ctl_t mk(input opa_t opa, input half_t half, input opb_t opb,
                                input acc_op_t acc_op, input sum_op_t sum_op,
                                input base_t base, input shift_t shift,
                                input dst_t dst, input seq_t seq);
        ctl_t c;
        c.opa    = opa;
        c.half   = half;
        c.opb    = opb;
        c.acc_op = acc_op;
        c.sum_op = sum_op;
        c.base   = base;
        c.shift  = shift;
        c.dst    = dst;
        c.seq    = seq;
        return c;
    endfunction

    // microprogram: a product issued at a step is registered in prod_reg, then loaded or added into acc
    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t c;
        c = CTL_NOP;
        unique case (step)
            STEP_W'(0):  c = mk(OA_CUR, HALF_LO, OB_CUR, ACC_HOLD, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(1):  c = mk(OA_I2, HALF_LO, OB_HEAT_GAIN, ACC_HOLD, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(2):  c = mk(OA_U, HALF_LO, OB_TEMPCO, ACC_HOLD, SUM_HOLD,
                                BASE_ONE, SH_32, DST_G, SEQ_NEXT);
            STEP_W'(3):  c = mk(OA_U, HALF_HI, OB_TEMPCO, ACC_LOAD, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(4):  c = mk(OA_U, HALF_LO, OB_COOL, ACC_ADD_HI, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(5):  c = mk(OA_U, HALF_HI, OB_COOL, ACC_LOAD, SUM_BASE_ADD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(6):  c = mk(OA_F, HALF_LO, OB_G, ACC_ADD_HI, SUM_HOLD,
                                BASE_ONE, SH_32, DST_F, SEQ_NEXT);
            STEP_W'(7):  c = mk(OA_F, HALF_LO, OB_G, ACC_HOLD, SUM_BASE_SUB,
                                BASE_U, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(8):  c = mk(OA_F, HALF_HI, OB_G, ACC_LOAD, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(9):  c = mk(OA_W, HALF_LO, OB_DAMP, ACC_ADD_HI, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(10): c = mk(OA_W, HALF_HI, OB_DAMP, ACC_LOAD, SUM_ADD,
                                BASE_ONE, SH_24, DST_NONE, SEQ_NEXT);
            STEP_W'(11): c = mk(OA_A, HALF_LO, OB_SPRING, ACC_ADD_HI, SUM_HOLD,
                                BASE_ONE, SH_32, DST_U, SEQ_NEXT);
            STEP_W'(12): c = mk(OA_A, HALF_HI, OB_SPRING, ACC_LOAD, SUM_BASE_SUB,
                                BASE_W, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(13): c = mk(OA_U, HALF_LO, OB_TORQUE, ACC_ADD_HI, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(14): c = mk(OA_U, HALF_HI, OB_TORQUE, ACC_LOAD, SUM_SUB,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(15): c = mk(OA_U, HALF_LO, OB_TORQUE, ACC_ADD_HI, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(16): c = mk(OA_U, HALF_LO, OB_TORQUE, ACC_HOLD, SUM_ADD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(17): c = mk(OA_U, HALF_LO, OB_TORQUE, ACC_HOLD, SUM_HOLD,
                                BASE_ONE, SH_32, DST_W, SEQ_NEXT);
            STEP_W'(18): c = mk(OA_W, HALF_LO, OB_TSTEP, ACC_HOLD, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(19): c = mk(OA_W, HALF_HI, OB_TSTEP, ACC_LOAD, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(20): c = mk(OA_W, HALF_LO, OB_TSTEP, ACC_ADD_HI, SUM_HOLD,
                                BASE_ONE, SH_32, DST_NONE, SEQ_NEXT);
            STEP_W'(21): c = mk(OA_W, HALF_LO, OB_TSTEP, ACC_HOLD, SUM_BASE_ADD,
                                BASE_A, SH_32, DST_NONE, SEQ_WAIT_OUT);
            STEP_W'(22): c = mk(OA_W, HALF_LO, OB_TSTEP, ACC_HOLD, SUM_HOLD,
                                BASE_ONE, SH_32, DST_A, SEQ_DONE);
            default:     c.seq = SEQ_DONE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/hwm_regs.sv =====
module hwm_regs
    import hwm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    output coef_t                coef
);

    coef_t coef_reg;
    coef_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEAT_GAIN:   coef_next.heat_gain   = cfg_data;
                REG_TEMPCO:      coef_next.tempco      = cfg_data;
                REG_COOL_COEF:   coef_next.cool_coef   = cfg_data;
                REG_TORQUE_COEF: coef_next.torque_coef = cfg_data;
                REG_DAMP_COEF:   coef_next.damp_coef   = cfg_data;
                REG_SPRING_COEF: coef_next.spring_coef = cfg_data;
                REG_TIME_STEP:   coef_next.time_step   = cfg_data;
                default:         coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.heat_gain   <= RST_HEAT_GAIN;
            coef_reg.tempco      <= RST_TEMPCO;
            coef_reg.cool_coef   <= RST_COOL_COEF;
            coef_reg.torque_coef <= RST_TORQUE_COEF;
            coef_reg.damp_coef   <= RST_DAMP_COEF;
            coef_reg.spring_coef <= RST_SPRING_COEF;
            coef_reg.time_step   <= RST_TIME_STEP;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// ===== rtl/hwm_seq.sv =====
module hwm_seq
    import hwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic out_room,
    output logic busy,
    output ctl_t ctl
);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        ctl       = busy_reg ? ucode(step_reg) : CTL_NOP;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
        else
        begin
            unique case (ctl.seq)
                SEQ_NEXT:
                begin
                    step_next = step_reg + STEP_W'(1);
                end
                SEQ_WAIT_OUT:
                begin
                    if (out_room)
                        step_next = step_reg + STEP_W'(1);
                end
                SEQ_DONE:
                begin
                    busy_next = 1'b0;
                    step_next = '0;
                end
                default:
                begin
                    busy_next = 1'b0;
                    step_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign busy = busy_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg < STEP_W'(NUM_STEPS))
        else $error("step counter ran past the microprogram");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy_reg |=> busy_reg && step_reg == '0)
        else $error("sequencer did not start at the first step");

endmodule

// ===== rtl/hwm_dpath.sv =====
module hwm_dpath
    import hwm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctl_t                    ctl,
    input  coef_t                   coef,
    input  logic                    load,
    input  logic signed [CUR_W-1:0] cur_in,
    input  logic                    last_in,
    input  logic                    out_ready,
    output logic                    out_room,
    output logic                    out_valid,
    output logic [ANGLE_W-1:0]      out_angle,
    output logic                    out_last
);

    logic signed [CUR_W-1:0]   cur_reg;
    logic                      last_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic [COEF_W-1:0]         g_reg;
    logic signed [STATE_W-1:0] f_reg;
    logic signed [STATE_W-1:0] u_reg;
    logic signed [STATE_W-1:0] u_next;
    logic signed [STATE_W-1:0] w_reg;
    logic signed [STATE_W-1:0] w_next;
    logic signed [STATE_W-1:0] a_reg;
    logic signed [STATE_W-1:0] a_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [ANGLE_W-1:0]        out_angle_reg;
    logic                      out_last_reg;

    logic signed [STATE_W-1:0] sel_state;
    logic signed [MUL_W-1:0]   opa;
    logic signed [MUL_W-1:0]   opb;
    logic signed [STATE_W-1:0] term;
    logic signed [SUM_W-1:0]   term_ext;
    logic signed [SUM_W-1:0]   base_val;
    logic signed [STATE_W-1:0] new_val;

    always_comb
    begin
        unique case (ctl.opa)
            OA_U:    sel_state = u_reg;
            OA_W:    sel_state = w_reg;
            OA_A:    sel_state = a_reg;
            default: sel_state = f_reg;
        endcase
        unique case (ctl.opa)
            OA_CUR:  opa = MUL_W'(cur_reg);
            OA_I2:   opa = {1'b0, prod_reg[MUL_LO_W-1:0]};
            default:
            begin
                if (ctl.half == HALF_HI)
                    opa = MUL_W'($signed(sel_state[STATE_W-1:MUL_LO_W]));
                else
                    opa = {1'b0, sel_state[MUL_LO_W-1:0]};
            end
        endcase
        unique case (ctl.opb)
            OB_CUR:       opb = MUL_W'(cur_reg);
            OB_HEAT_GAIN: opb = {1'b0, coef.heat_gain};
            OB_TEMPCO:    opb = {1'b0, coef.tempco};
            OB_COOL:      opb = {1'b0, coef.cool_coef};
            OB_TORQUE:    opb = {1'b0, coef.torque_coef};
            OB_DAMP:      opb = {1'b0, coef.damp_coef};
            OB_SPRING:    opb = {1'b0, coef.spring_coef};
            OB_TSTEP:     opb = {1'b0, coef.time_step};
            default:      opb = {1'b0, g_reg};
        endcase
    end

    always_comb
    begin
        unique case (ctl.acc_op)
            ACC_LOAD:   acc_next = ACC_W'(prod_reg);
            ACC_ADD_HI: acc_next = acc_reg + (ACC_W'(prod_reg) <<< MUL_LO_W);
            default:    acc_next = acc_reg;
        endcase

        if (ctl.shift == SH_24)
            term = sat_state(acc_reg >>> HEAT_SHIFT);
        else
            term = sat_state(acc_reg >>> COEF_SHIFT);
        term_ext = SUM_W'(term);

        unique case (ctl.base)
            BASE_U:  base_val = SUM_W'(u_reg);
            BASE_W:  base_val = SUM_W'(w_reg);
            BASE_A:  base_val = SUM_W'(a_reg);
            default: base_val = SUM_ONE;
        endcase

        unique case (ctl.sum_op)
            SUM_BASE_ADD: sum_next = base_val + term_ext;
            SUM_BASE_SUB: sum_next = base_val - term_ext;
            SUM_ADD:      sum_next = sum_reg + term_ext;
            SUM_SUB:      sum_next = sum_reg - term_ext;
            default:      sum_next = sum_reg;
        endcase
    end

    assign new_val = sat_state(ACC_W'(sum_reg));

    always_comb
    begin
        u_next         = u_reg;
        w_next         = w_reg;
        a_next         = a_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (ctl.dst)
            DST_U: u_next = new_val;
            DST_W: w_next = new_val;
            DST_A:
            begin
                out_valid_next = 1'b1;
                if (new_val[STATE_W-1])
                begin
                    a_next = '0;
                    w_next = '0;
                end
                else
                begin
                    a_next = new_val;
                end
            end
            default: u_next = u_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_reg         <= '0;
            w_reg         <= '0;
            a_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            u_reg         <= u_next;
            w_reg         <= w_next;
            a_reg         <= a_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        acc_reg  <= acc_next;
        sum_reg  <= sum_next;
        if (load)
        begin
            cur_reg  <= cur_in;
            last_reg <= last_in;
        end
        if (ctl.dst == DST_G)
            g_reg <= prod_reg[2*MUL_LO_W-1:MUL_LO_W];
        if (ctl.dst == DST_F)
            f_reg <= new_val;
        if (ctl.dst == DST_A)
        begin
            out_angle_reg <= to_angle(a_next);
            out_last_reg  <= last_reg;
        end
    end

    assign out_room  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_angle = out_angle_reg;
    assign out_last  = out_last_reg;

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.dst == DST_A |-> !out_valid_reg)
        else $error("result written over a word not yet taken");

    a_angle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.dst == DST_A |=> !a_reg[STATE_W-1])
        else $error("needle angle negative after update");

    a_clamp_rate: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.dst == DST_A && new_val[STATE_W-1] |=> w_reg == '0 && a_reg == '0)
        else $error("clamp did not zero angle and rate");

endmodule

// ===== rtl/hot_wire_meter_needle_model.sv =====
// Hot-wire meter needle model: one current sample in, one needle angle out.
// Input stream (s_*): a word carries a signed Q4.12 current sample in tdata
// and the end-of-block flag in tlast. Output stream (m_*): the needle angle
// as unsigned Q8.24 in tdata, saturating, with tlast copied from the input.
// Configuration: cfg_we writes cfg_data into the coefficient at cfg_index
// (0 heat_gain .. 6 time_step); index 7 is ignored. Write only while idle.
// Each sample runs a 23-step microprogram on one 33x33 multiplier with an
// accumulator and a summing register; the result is written to the output
// register at the last step. The sixteen products share the multiplier and
// the chain temperature, rate, angle runs in order, so the block takes a new
// sample only once the last one is through (s_tready is low while busy).
// The output register holds one finished word; while it waits the next
// sample is accepted and computed, and the program stalls on its next-to-last
// step until the waiting word is taken.
// Reset clears the temperature rise, rate and angle to zero and loads the
// default coefficients; nothing needs to be swept.
module hot_wire_meter_needle_model
    import hwm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic signed [CUR_W-1:0] s_tdata,   // [15:0] current_sample
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [ANGLE_W-1:0]      m_tdata,   // [31:0] needle_angle
    output logic                    m_tlast,
    input  logic                    cfg_we,
    input  logic [REG_IDX_W-1:0]    cfg_index,
    input  logic [COEF_W-1:0]       cfg_data
);

    coef_t coef;
    ctl_t  ctl;
    logic  busy;
    logic  accept;
    logic  out_room;

    assign s_tready = !busy;
    assign accept   = s_tvalid && !busy;

    hwm_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    hwm_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .out_room (out_room),
        .busy     (busy),
        .ctl      (ctl)
    );

    hwm_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .coef      (coef),
        .load      (accept),
        .cur_in    (s_tdata),
        .last_in   (s_tlast),
        .out_ready (m_tready),
        .out_room  (out_room),
        .out_valid (m_tvalid),
        .out_angle (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
